@@ sv/lpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lpcs_pkg
// Shared constants, types and helper functions of the linear probing
// character set: widths, result status codes and the modulo unit handshake.
// ----------------------------------------------------------------------------
package lpcs_pkg;

  // Table geometry.
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned STATUS_W  = 3;

  // Capacity after reset when the register was never written.
  localparam logic [CAP_W-1:0] RESET_INIT_CAP = CAP_W'(5);
  localparam logic [CAP_W-1:0] MAX_CAP        = CAP_W'(MAX_SLOTS);

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_DUP         = 3'd1,
    ST_GROWN       = 3'd2,
    ST_DROPPED     = 3'd3,
    ST_FLUSH       = 3'd4,
    ST_FLUSH_EMPTY = 3'd5
  } status_e;

  // Request to the modulo unit.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [CAP_W-1:0] divisor;
  } mod_req_t;

  // Answer of the modulo unit.
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  // Clamp the programmed capacity into the range 1 to MAX_SLOTS.
  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] raw);
    logic [CAP_W-1:0] c;
    c = raw;
    if (raw == '0) begin
      c = CAP_W'(1);
    end else if (raw > MAX_CAP) begin
      c = MAX_CAP;
    end
    return c;
  endfunction

  // Doubled capacity, saturating at the slot limit.
  function automatic logic [CAP_W-1:0] grow_cap(input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] dbl;
    logic [CAP_W-1:0] c;
    dbl = {cap, 1'b0};
    if (dbl > {1'b0, MAX_CAP}) begin
      c = MAX_CAP;
    end else begin
      c = dbl[CAP_W-1:0];
    end
    return c;
  endfunction

endpackage

@@ sv/lpcs_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lpcs_cfg_if
// Configuration write channel carrying the initial capacity word.
// ----------------------------------------------------------------------------
interface lpcs_cfg_if import lpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] initial_capacity;

  modport source (output valid, output initial_capacity, input ready);
  modport sink   (input valid, input initial_capacity, output ready);
endinterface

@@ sv/lpcs_in_if.sv @@
// ----------------------------------------------------------------------------
// lpcs_in_if
// Input channel: one command word with its key.
// ----------------------------------------------------------------------------
interface lpcs_in_if import lpcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

@@ sv/lpcs_out_if.sv @@
// ----------------------------------------------------------------------------
// lpcs_out_if
// Result channel: status, key, distinct count and last flag of each word.
// ----------------------------------------------------------------------------
interface lpcs_out_if import lpcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_out;
  logic [CAP_W-1:0]    distinct_count;
  logic                last;

  modport source (output valid, output status, output key_out,
                  output distinct_count, output last, input ready);
  modport sink   (input valid, input status, input key_out,
                  input distinct_count, input last, output ready);
endinterface

@@ sv/linear_probe_char_set.sv @@
// ----------------------------------------------------------------------------
// linear_probe_char_set
// Set of distinct non-zero byte keys in an open-addressed table with linear
// probing, growth by doubling with reinsertion, and flush in slot order.
// ----------------------------------------------------------------------------
// Insert: the modulo unit gives the home slot, and each probe is a slot RAM read
//   and a compare, until a free slot or the key itself is found; the result word
//   is then registered for the output.
// Growth first gathers the C old slots into the rehash RAM, then reinserts each key.
// Flush: a read and a check per slot scanned, plus output stalls; one item at a time.
// After reset the table is empty with capacity 5; no clearing pass is needed.
module linear_probe_char_set import lpcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpcs_cfg_if.sink   cfg_i,
  lpcs_in_if.sink    in_i,
  lpcs_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOME,
    S_PRD,
    S_PCHK,
    S_GRD,
    S_GCHK,
    S_RRD,
    S_RKEY,
    S_FRD,
    S_FCHK,
    S_RESULT
  } state_e;

  typedef enum logic [1:0] {
    PM_INSERT,
    PM_REHASH,
    PM_FINAL
  } probe_mode_e;

  // Control state.
  state_e              state_q, state_d;
  probe_mode_e         mode_q, mode_d;
  logic [CAP_W-1:0]    init_cap_q, init_cap_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [CAP_W-1:0]    count_q, count_d;
  logic [MAX_SLOTS-1:0] valid_q, valid_d;
  logic                rd_vld_q, rd_vld_d;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  logic [CAP_W-1:0]    step_q, step_d;
  logic [CAP_W-1:0]    idx_q, idx_d;
  logic [CAP_W-1:0]    n_q, n_d;
  logic [CAP_W-1:0]    j_q, j_d;

  // Payload registers.
  logic [KEY_W-1:0]    key_q, key_d;
  logic [KEY_W-1:0]    cur_key_q, cur_key_d;
  status_e             res_status_q, res_status_d;
  status_e             out_status_q, out_status_d;
  logic [KEY_W-1:0]    out_key_q, out_key_d;
  logic [CAP_W-1:0]    out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  // Memory and unit ports.
  logic                slot_we, slot_re;
  logic [IDX_W-1:0]    slot_waddr, slot_raddr;
  logic [KEY_W-1:0]    slot_wdata, slot_rdata;
  logic                buf_we, buf_re;
  logic [IDX_W-1:0]    buf_waddr, buf_raddr;
  logic [KEY_W-1:0]    buf_wdata, buf_rdata;
  mod_req_t            mod_req;
  mod_rsp_t            mod_rsp;

  logic [KEY_W-1:0]    slot_val;
  logic                out_free;
  logic                in_fire;
  logic [IDX_W-1:0]    pos_inc;
  logic                probe_empty, probe_dup, probe_full;
  logic                flush_last;

  lpcs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  lpcs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_SLOTS)
  ) u_rehash_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  lpcs_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Handshakes and slot decode.
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign slot_val    = rd_vld_q ? slot_rdata : '0;
  assign probe_empty = (slot_val == '0);
  assign probe_dup   = (slot_val == cur_key_q);
  assign probe_full  = ((step_q + CAP_W'(1)) == cap_q);
  assign flush_last  = ((j_q + CAP_W'(1)) == count_q);
  assign pos_inc     = ((CAP_W'(pos_q) + CAP_W'(1)) == cap_q) ? '0 : pos_q + IDX_W'(1);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    init_cap_d   = init_cap_q;
    cap_d        = cap_q;
    count_d      = count_q;
    valid_d      = valid_q;
    rd_vld_d     = rd_vld_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    pos_d        = pos_q;
    step_d       = step_q;
    idx_d        = idx_q;
    n_d          = n_q;
    j_d          = j_q;
    key_d        = key_q;
    cur_key_d    = cur_key_q;
    res_status_d = res_status_q;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    slot_we      = 1'b0;
    slot_waddr   = pos_q;
    slot_wdata   = cur_key_q;
    slot_re      = 1'b0;
    slot_raddr   = pos_q;
    buf_we       = 1'b0;
    buf_waddr    = n_q[IDX_W-1:0];
    buf_wdata    = slot_val;
    buf_re       = 1'b0;
    buf_raddr    = j_q[IDX_W-1:0];
    mod_req      = '{start: 1'b0, dividend: cur_key_q, divisor: cap_q};

    // Register write.
    if (cfg_i.valid) begin
      init_cap_d = cfg_i.initial_capacity;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.command) begin
            key_d = '0;
            if (count_q == '0) begin
              res_status_d = ST_FLUSH_EMPTY;
              valid_d      = '0;
              cap_d        = eff_cap(init_cap_q);
              count_d      = '0;
              state_d      = S_RESULT;
            end else begin
              idx_d   = '0;
              j_d     = '0;
              state_d = S_FRD;
            end
          end else if (in_i.key == '0) begin
            key_d        = '0;
            res_status_d = ST_DROPPED;
            state_d      = S_RESULT;
          end else begin
            key_d     = in_i.key;
            cur_key_d = in_i.key;
            mode_d    = PM_INSERT;
            mod_req   = '{start: 1'b1, dividend: in_i.key, divisor: cap_q};
            state_d   = S_HOME;
          end
        end
      end

      // Wait for the home slot.
      S_HOME: begin
        if (mod_rsp.done) begin
          pos_d   = mod_rsp.rem;
          step_d  = '0;
          state_d = S_PRD;
        end
      end

      S_PRD: begin
        slot_re  = 1'b1;
        rd_vld_d = valid_q[pos_q];
        state_d  = S_PCHK;
      end

      // Compare one slot and decide the next probe step.
      S_PCHK: begin
        if (probe_empty) begin
          slot_we        = 1'b1;
          valid_d[pos_q] = 1'b1;
          count_d        = count_q + CAP_W'(1);
          unique case (mode_q)
            PM_INSERT: begin
              res_status_d = ST_ADDED;
              state_d      = S_RESULT;
            end
            PM_FINAL: begin
              res_status_d = ST_GROWN;
              state_d      = S_RESULT;
            end
            PM_REHASH: begin
              j_d = j_q + CAP_W'(1);
              if ((j_q + CAP_W'(1)) == n_q) begin
                cur_key_d = key_q;
                mode_d    = PM_FINAL;
                mod_req   = '{start: 1'b1, dividend: key_q, divisor: cap_q};
                state_d   = S_HOME;
              end else begin
                state_d = S_RRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end else if (probe_dup) begin
          res_status_d = ST_DUP;
          state_d      = S_RESULT;
        end else if (probe_full) begin
          if (cap_q >= MAX_CAP) begin
            res_status_d = ST_DROPPED;
            state_d      = S_RESULT;
          end else begin
            idx_d   = '0;
            n_d     = '0;
            state_d = S_GRD;
          end
        end else begin
          step_d  = step_q + CAP_W'(1);
          pos_d   = pos_inc;
          state_d = S_PRD;
        end
      end

      // Gather the old keys, then clear and enlarge the table.
      S_GRD: begin
        if (idx_q == cap_q) begin
          cap_d   = grow_cap(cap_q);
          valid_d = '0;
          count_d = '0;
          j_d     = '0;
          if (n_q == '0) begin
            cur_key_d = key_q;
            mode_d    = PM_FINAL;
            mod_req   = '{start: 1'b1, dividend: key_q, divisor: grow_cap(cap_q)};
            state_d   = S_HOME;
          end else begin
            state_d = S_RRD;
          end
        end else begin
          slot_re    = 1'b1;
          slot_raddr = idx_q[IDX_W-1:0];
          rd_vld_d   = valid_q[idx_q[IDX_W-1:0]];
          state_d    = S_GCHK;
        end
      end

      S_GCHK: begin
        if (!probe_empty) begin
          buf_we = 1'b1;
          n_d    = n_q + CAP_W'(1);
        end
        idx_d   = idx_q + CAP_W'(1);
        state_d = S_GRD;
      end

      // Reinsert the gathered keys in order.
      S_RRD: begin
        buf_re  = 1'b1;
        state_d = S_RKEY;
      end

      S_RKEY: begin
        cur_key_d = buf_rdata;
        mode_d    = PM_REHASH;
        mod_req   = '{start: 1'b1, dividend: buf_rdata, divisor: cap_q};
        state_d   = S_HOME;
      end

      // Flush: walk the slots and emit each stored key.
      S_FRD: begin
        if (idx_q == cap_q) begin
          valid_d = '0;
          cap_d   = eff_cap(init_cap_q);
          count_d = '0;
          state_d = S_IDLE;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = idx_q[IDX_W-1:0];
          rd_vld_d   = valid_q[idx_q[IDX_W-1:0]];
          state_d    = S_FCHK;
        end
      end

      S_FCHK: begin
        if (probe_empty) begin
          idx_d   = idx_q + CAP_W'(1);
          state_d = S_FRD;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_FLUSH;
          out_key_d    = slot_val;
          out_count_d  = '0;
          out_last_d   = flush_last;
          j_d          = j_q + CAP_W'(1);
          idx_d        = idx_q + CAP_W'(1);
          if (flush_last) begin
            valid_d = '0;
            cap_d   = eff_cap(init_cap_q);
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_FRD;
          end
        end
      end

      // Hand the single result word of an insert or empty flush to the output.
      S_RESULT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = key_q;
          out_count_d  = count_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= PM_INSERT;
      init_cap_q  <= RESET_INIT_CAP;
      cap_q       <= eff_cap(RESET_INIT_CAP);
      count_q     <= '0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      n_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      init_cap_q  <= init_cap_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      j_q         <= j_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    cur_key_q    <= cur_key_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  // Output word.
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.key_out        = out_key_q;
  assign out_o.distinct_count = out_count_q;
  assign out_o.last           = out_last_q;

  // The table never holds more keys than it has slots.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("key count exceeds capacity");

  // Capacity stays within 1 to MAX_SLOTS.
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= MAX_CAP))
    else $error("capacity out of range");

  // Every probed slot lies inside the current capacity.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (CAP_W'(pos_q) < cap_q))
    else $error("probe position beyond capacity");

endmodule

@@ sv/lpcs_ram.sv @@
// ----------------------------------------------------------------------------
// lpcs_ram
// Generic single write port, single read port RAM with registered read data.
// The read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module lpcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lpcs_mod_unit.sv @@
// ----------------------------------------------------------------------------
// lpcs_mod_unit
// Restoring remainder unit: key modulo capacity, one dividend bit per cycle.
// A start launches KEY_W steps; done pulses once with the remainder.
// ----------------------------------------------------------------------------
module lpcs_mod_unit import lpcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mod_state_e;

  localparam int unsigned CNT_W = $clog2(KEY_W);

  mod_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] num_q, num_d;
  logic [CAP_W-1:0] div_q, div_d;
  logic [CAP_W-1:0] rem_q, rem_d;
  logic             done_q, done_d;
  logic [KEY_W-1:0] trial;

  // One shift and conditional subtract per cycle.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    div_d   = div_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    trial   = {rem_q, num_q[KEY_W-1]};
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          num_d   = req_i.dividend;
          div_d   = req_i.divisor;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = M_RUN;
        end
      end
      M_RUN: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = CAP_W'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CAP_W-1:0];
        end
        num_d = {num_q[KEY_W-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(KEY_W - 1)) begin
          done_d  = 1'b1;
          state_d = M_IDLE;
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      num_q   <= '0;
      div_q   <= CAP_W'(1);
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      num_q   <= num_d;
      div_q   <= div_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[IDX_W-1:0];

  // The remainder handed out is always below the divisor.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < div_q))
    else $error("modulo result not below divisor");

  // The sequencer never restarts the unit while it is working.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == M_RUN) |-> !req_i.start)
    else $error("modulo unit started while busy");

endmodule
